// ===== src/sliding_min_queue_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sliding minimum queue.
// Each macro expects signals named clk and rst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef SLIDING_MIN_QUEUE_ASSERT_SVH
`define SLIDING_MIN_QUEUE_ASSERT_SVH

// Same-cycle implication.
`define SMQ_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SMQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/smq_pkg.sv =====
// ----------------------------------------------------------------------------
// smq_pkg
// Item types, action codes and helpers shared by the sliding minimum queue.
// ----------------------------------------------------------------------------
package smq_pkg;

  localparam logic [1:0] ACT_PUSH    = 2'd0;
  localparam logic [1:0] ACT_POP     = 2'd1;
  localparam logic [1:0] ACT_POPPUSH = 2'd2;

  localparam logic signed [31:0] EMPTY_MIN = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] minimum;
    logic               is_empty;
    logic [10:0]        occupancy;
    logic               error;
  } out_item_t;

  function automatic logic signed [31:0] smin(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    smin = (a < b) ? a : b;
  endfunction

endpackage

// ===== src/smq_stack_ram.sv =====
// ----------------------------------------------------------------------------
// smq_stack_ram
// Single-port-write, single-port-read stack memory with a registered read.
// ----------------------------------------------------------------------------
module smq_stack_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/sliding_min_queue.sv =====
// ----------------------------------------------------------------------------
// sliding_min_queue
// FIFO of signed values that reports the minimum of its contents, built as
// an in-stack of values and an out-stack of running minima.
//
//   channel  ports                          direction
//   in       in_valid in_ready in_data      item in (action, value)
//   out      out_valid out_ready out_data   result out (one per item)
//
// A push runs through S_EXEC and S_DONE. A pop from a non-empty out-stack
// adds S_TAIL, and S_POPRD for the registered read of the out-stack memory.
// A pop that finds the out-stack empty first moves the in-stack over, one
// entry per cycle through the in-stack read port.
// The next item is taken while a result still waits in the output register.
// Reset clears the counts; the memories need no clearing pass.
// ----------------------------------------------------------------------------
module sliding_min_queue
  import smq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 1024
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  `include "sliding_min_queue_assert.svh"

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_POPRD,
    S_XFER,
    S_TAIL,
    S_DONE
  } state_t;

  state_t             state_r;
  logic [1:0]         action_r;
  logic signed [31:0] value_r;
  logic               err_r;
  logic [CW-1:0]      in_cnt_r;
  logic [CW-1:0]      out_cnt_r;
  logic signed [31:0] in_min_r;
  logic signed [31:0] out_top_r;
  logic [CW-1:0]      rd_r;
  logic [CW-1:0]      wr_r;
  logic               pend_r;
  logic               out_valid_r;
  out_item_t          out_data_r;

  logic [CW-1:0]      held;
  logic [31:0]        held_w;
  logic               accept;
  logic               acc_err;
  logic               pop_op;
  logic               push_now;
  logic signed [31:0] push_min;
  logic signed [31:0] xfer_run;
  logic signed [31:0] min_now;
  logic [CW-1:0]      out_below;
  logic               load_out;

  logic               in_we;
  logic               in_re;
  logic [31:0]        in_rdata;
  logic               out_we;
  logic               out_re;
  logic [31:0]        out_rdata;

  assign held     = in_cnt_r + out_cnt_r;
  assign held_w   = 32'(held);
  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    unique case (in_data.action)
      ACT_PUSH:    acc_err = (held >= DEPTH_C);
      ACT_POP:     acc_err = (held == '0);
      ACT_POPPUSH: acc_err = (held == '0);
      default:     acc_err = 1'b1;
    endcase
  end

  assign pop_op   = !err_r && ((action_r == ACT_POP) || (action_r == ACT_POPPUSH));
  assign push_now = !err_r &&
                    (((state_r == S_EXEC) && (action_r == ACT_PUSH)) ||
                     ((state_r == S_TAIL) && (action_r == ACT_POPPUSH)));
  assign push_min = (in_cnt_r == '0) ? value_r : smin(value_r, in_min_r);
  assign xfer_run = (wr_r == '0) ? $signed(in_rdata) : smin(out_top_r, $signed(in_rdata));
  assign min_now  = smin((in_cnt_r != '0) ? in_min_r : EMPTY_MIN,
                         (out_cnt_r != '0) ? out_top_r : EMPTY_MIN);
  assign out_below = out_cnt_r - CW'(2);
  assign load_out  = (state_r == S_DONE) && (!out_valid_r || out_ready);

  assign in_we  = push_now;
  assign in_re  = (state_r == S_XFER) && (rd_r != '0);
  assign out_we = (state_r == S_XFER) && pend_r;
  assign out_re = (state_r == S_EXEC) && pop_op && (out_cnt_r >= CW'(2));

  smq_stack_ram #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (32)
  ) u_in_stack (
    .clk   (clk),
    .we    (in_we),
    .waddr (in_cnt_r[AW-1:0]),
    .wdata (value_r),
    .re    (in_re),
    .raddr (rd_r[AW-1:0]),
    .rdata (in_rdata)
  );

  smq_stack_ram #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (32)
  ) u_out_stack (
    .clk   (clk),
    .we    (out_we),
    .waddr (wr_r[AW-1:0]),
    .wdata (xfer_run),
    .re    (out_re),
    .raddr (out_below[AW-1:0]),
    .rdata (out_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_cnt_r    <= '0;
      out_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && !load_out) begin
        out_valid_r <= 1'b0;
      end
      if (push_now) begin
        in_min_r <= push_min;
        in_cnt_r <= in_cnt_r + CW'(1);
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            action_r <= in_data.action;
            value_r  <= in_data.value;
            err_r    <= acc_err;
            state_r  <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (!pop_op) begin
            state_r <= S_DONE;
          end else if (out_cnt_r == '0) begin
            if (in_cnt_r == CW'(1)) begin
              in_cnt_r <= '0;
              state_r  <= S_TAIL;
            end else begin
              rd_r    <= in_cnt_r - CW'(1);
              wr_r    <= '0;
              pend_r  <= 1'b0;
              state_r <= S_XFER;
            end
          end else begin
            out_cnt_r <= out_cnt_r - CW'(1);
            state_r   <= (out_cnt_r >= CW'(2)) ? S_POPRD : S_TAIL;
          end
        end
        S_POPRD: begin
          out_top_r <= $signed(out_rdata);
          state_r   <= S_TAIL;
        end
        S_XFER: begin
          pend_r <= in_re;
          if (in_re) begin
            rd_r <= rd_r - CW'(1);
          end
          if (pend_r) begin
            out_top_r <= xfer_run;
            wr_r      <= wr_r + CW'(1);
          end
          if (!in_re && !pend_r) begin
            out_cnt_r <= wr_r;
            in_cnt_r  <= '0;
            state_r   <= S_TAIL;
          end
        end
        S_TAIL: begin
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (load_out) begin
            out_valid_r          <= 1'b1;
            out_data_r.minimum   <= min_now;
            out_data_r.is_empty  <= (held == '0);
            out_data_r.occupancy <= held_w[10:0];
            out_data_r.error     <= err_r;
            state_r              <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `SMQ_ASSERT_IMPL(a_capacity, 1'b1, (in_cnt_r + out_cnt_r) <= DEPTH_C, "queue over capacity")
  `SMQ_ASSERT_IMPL(a_xfer_empty, state_r == S_XFER, out_cnt_r == '0, "out-stack busy in move")
  `SMQ_ASSERT_NEXT(a_accept_exec, accept, state_r == S_EXEC, "accepted item not executed")
  `SMQ_ASSERT_NEXT(a_result_load, load_out, out_valid_r, "finished result not presented")

endmodule
